FILE: sv/srn_pkg.sv
// Shared types and constants for the shift, zero and RMS normalize block.
`default_nettype none
package srn_pkg;

    localparam int SAMP_W  = 16;
    localparam int SCALE_W = 16;
    localparam int VAL_W   = 32;
    localparam int QUO_W   = 32;
    localparam int FRAC_W  = 16;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ZERO_NORM  = 2'd1;
    localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                     operation;
        logic signed [SAMP_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic [1:0]              status;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT,
        ST_FETCH,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

FILE: sv/srn_isqrt.sv
// Bit-pair serial integer square root of (radicand << 16), one root bit per cycle.
`default_nettype none
module srn_isqrt #(
    parameter int SUM_W = 39
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [SUM_W-1:0]                       radicand,
    output logic                                   done,
    output logic [(SUM_W+srn_pkg::FRAC_W+1)/2-1:0] root
);
    import srn_pkg::*;

    localparam int RW    = (SUM_W + FRAC_W + 1) / 2;
    localparam int X_W   = 2 * RW;
    localparam int CNT_W = $clog2(RW);

    logic [X_W-1:0]   x_reg, x_next;
    logic [RW+1:0]    rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic             take;

    assign rem_sh = {rem_reg[RW-1:0], x_reg[X_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = X_W'({radicand, {FRAC_W{1'b0}}});
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            x_next    = {x_reg[X_W-3:0], 2'b00};
            rem_next  = take ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[RW-2:0], take};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

FILE: sv/srn_div.sv
// Restoring bit-serial divider: (dividend << 32) / divisor, rounded half away from zero.
`default_nettype none
module srn_div #(
    parameter int NH_W = 20,
    parameter int D_W  = 44
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NH_W-1:0]          dividend,
    input  logic [D_W-1:0]           divisor,
    output logic                     done,
    output logic [srn_pkg::QUO_W:0]  quotient
);
    import srn_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [D_W:0]     rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [QUO_W:0]   qr_reg, qr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [D_W:0]     rem_sh;
    logic             ge;

    // dividend < divisor on entry, so the remainder stays below the divisor
    assign rem_sh = {rem_reg[D_W-1:0], 1'b0};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        qr_next   = qr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = (D_W+1)'(dividend);
            dvs_next  = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(QUO_W))
            begin
                // twice the remainder against the divisor decides the round-up
                qr_next   = {1'b0, q_reg} + (QUO_W+1)'(ge);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                q_next   = {q_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        qr_reg  <= qr_next;
    end

    assign done     = done_reg;
    assign quotient = qr_reg;

endmodule
`default_nettype wire

FILE: sv/shift_zero_rms_normalize.sv
// A load passes through the square and accumulate states; the load that completes a matrix
// also runs the square root: RW = (SUM_W + 17) / 2 is the root width (28 at SIZE 16), one
// root bit per cycle. A read of a loaded matrix fetches the sample, then runs the bit-serial
// divider (32 quotient bits plus rounding); zero, centre and saturated reads skip it.
// A read before a full load returns a not-loaded status. Reset clears counters, square sum,
// and divisor, sets the scale to 256; sample store contents are undefined until loaded.
`default_nettype none
module shift_zero_rms_normalize #(
    parameter int SIZE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  srn_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output srn_pkg::out_t                       out_data,
    input  logic                                cfg_wr_en,
    input  logic [srn_pkg::SCALE_W-1:0]         cfg_wr_data
);
    import srn_pkg::*;

    localparam int ELEMS  = SIZE * SIZE;
    localparam int ADDR_W = $clog2(ELEMS);
    localparam int CNT_W  = $clog2(ELEMS + 1);
    localparam int POS_W  = $clog2(SIZE);
    localparam int HALF   = SIZE / 2;
    localparam int ZPOS   = (2 * HALF) % SIZE;
    localparam int SUM_W  = 31 + ADDR_W;
    localparam int RW     = (SUM_W + FRAC_W + 1) / 2;
    localparam int D_W    = RW + SCALE_W;
    localparam int NH_W   = SAMP_W + POS_W;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(SIZE - 1);
    localparam logic [POS_W-1:0] HALF_POS = POS_W'(HALF);
    localparam logic [POS_W-1:0] ZERO_POS = POS_W'(ZPOS);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ELEMS);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    load_count_reg, load_count_next;
    logic [POS_W-1:0]    ld_row_reg, ld_row_next;
    logic [POS_W-1:0]    ld_col_reg, ld_col_next;
    logic [POS_W-1:0]    rd_a_reg, rd_a_next;
    logic [POS_W-1:0]    rd_b_reg, rd_b_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [D_W-1:0]      divisor_reg, divisor_next;
    logic [SCALE_W-1:0]  scale_reg;
    logic [SCALE_W-1:0]  scale_use_reg, scale_use_next;
    logic                out_valid_reg, out_valid_next;

    logic signed [SAMP_W-1:0] samp_reg, samp_next;
    logic [30:0]         sq_reg, sq_next;
    logic                excl_reg, excl_next;
    logic                last_reg, last_next;
    logic                neg_reg, neg_next;
    out_t                res_reg, res_next;
    out_t                out_data_reg;
    logic [SAMP_W-1:0]   mem_q_reg;
    logic [SAMP_W-1:0]   store_mem [ELEMS];

    logic                full;
    logic                out_load;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [POS_W:0]      r_sum;
    logic [POS_W:0]      c_sum;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    c_pos;
    logic signed [31:0]  sq_prod;
    logic [SAMP_W-1:0]   mag;
    logic [NH_W-1:0]     nh;
    logic [QUO_W-1:0]    neg_q;

    logic                sqrt_start;
    logic                sqrt_done;
    logic [RW-1:0]       sqrt_root;
    logic                div_start;
    logic                div_done;
    logic [QUO_W:0]      div_q;

    srn_isqrt #(
        .SUM_W (SUM_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_next),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    srn_div #(
        .NH_W (NH_W),
        .D_W  (D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (nh),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign full     = load_count_reg == FULL_CNT;
    assign in_stall = state_reg != ST_IDLE;

    // transposed quadrant swap: output (a,b) reads stored (b+H, a+H) mod SIZE
    assign r_sum   = {1'b0, rd_b_reg} + (POS_W+1)'(HALF);
    assign c_sum   = {1'b0, rd_a_reg} + (POS_W+1)'(HALF);
    assign r_pos   = (r_sum >= (POS_W+1)'(SIZE)) ? POS_W'(r_sum - (POS_W+1)'(SIZE))
                                                 : r_sum[POS_W-1:0];
    assign c_pos   = (c_sum >= (POS_W+1)'(SIZE)) ? POS_W'(c_sum - (POS_W+1)'(SIZE))
                                                 : c_sum[POS_W-1:0];
    assign rd_addr = ADDR_W'(r_pos) * ADDR_W'(SIZE) + ADDR_W'(c_pos);
    assign wr_addr = full ? '0 : load_count_reg[ADDR_W-1:0];

    assign sq_prod = samp_reg * samp_reg;
    assign mag     = mem_q_reg[SAMP_W-1] ? (~mem_q_reg + 1'b1) : mem_q_reg;
    assign nh      = NH_W'(mag) * NH_W'(SIZE);
    assign neg_q   = ~div_q[QUO_W-1:0] + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        ld_row_next     = ld_row_reg;
        ld_col_next     = ld_col_reg;
        rd_a_next       = rd_a_reg;
        rd_b_next       = rd_b_reg;
        sum_next        = sum_reg;
        divisor_next    = divisor_reg;
        scale_use_next  = scale_use_reg;
        samp_next       = samp_reg;
        sq_next         = sq_reg;
        excl_next       = excl_reg;
        last_next       = last_reg;
        neg_next        = neg_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        sqrt_start      = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.operation == OP_LOAD)
                    begin
                        mem_we    = 1'b1;
                        samp_next = in_data.sample;
                        // scale in force when the load is taken
                        scale_use_next = scale_reg;
                        // row and column counters wrap back to zero on a full matrix
                        excl_next = (ld_row_reg == ZERO_POS) || (ld_col_reg == ZERO_POS);
                        if (full)
                        begin
                            load_count_next = CNT_W'(1);
                            sum_next        = '0;
                            rd_a_next       = '0;
                            rd_b_next       = '0;
                        end
                        else
                        begin
                            load_count_next = load_count_reg + 1'b1;
                        end
                        if (ld_col_reg == LAST_POS)
                        begin
                            ld_col_next = '0;
                            ld_row_next = (ld_row_reg == LAST_POS) ? '0 : ld_row_reg + 1'b1;
                        end
                        else
                        begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                        state_next = ST_SQUARE;
                    end
                    else if (!full)
                    begin
                        res_next.value  = '0;
                        res_next.last   = 1'b0;
                        res_next.status = STATUS_NOT_LOADED;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        excl_next = (rd_a_reg == HALF_POS) || (rd_b_reg == HALF_POS);
                        last_next = (rd_a_reg == LAST_POS) && (rd_b_reg == LAST_POS);
                        if (rd_b_reg == LAST_POS)
                        begin
                            rd_b_next = '0;
                            rd_a_next = (rd_a_reg == LAST_POS) ? '0 : rd_a_reg + 1'b1;
                        end
                        else
                        begin
                            rd_b_next = rd_b_reg + 1'b1;
                        end
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_SQUARE:
            begin
                sq_next    = sq_prod[30:0];
                state_next = ST_ACCUM;
            end

            ST_ACCUM:
            begin
                if (!excl_reg)
                begin
                    sum_next = sum_reg + SUM_W'(sq_reg);
                end
                if (full)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    divisor_next = D_W'(sqrt_root) * D_W'(scale_use_reg);
                    state_next   = ST_IDLE;
                end
            end

            ST_FETCH:
            begin
                res_next.last   = last_reg;
                res_next.status = STATUS_OK;
                res_next.value  = '0;
                neg_next        = !mem_q_reg[SAMP_W-1];
                if (divisor_reg == '0)
                begin
                    res_next.status = STATUS_ZERO_NORM;
                    state_next      = ST_EMIT;
                end
                else if (excl_reg || (mem_q_reg == '0))
                begin
                    state_next = ST_EMIT;
                end
                else if (D_W'(nh) >= divisor_reg)
                begin
                    // quotient reaches 2^32: saturates whatever the low bits
                    res_next.value = mem_q_reg[SAMP_W-1] ? VAL_MAX : VAL_MIN;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (|div_q[QUO_W:QUO_W-1])
                    begin
                        res_next.value = neg_reg ? VAL_MIN : VAL_MAX;
                    end
                    else
                    begin
                        res_next.value = neg_reg ? neg_q : div_q[QUO_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            rd_a_reg       <= '0;
            rd_b_reg       <= '0;
            sum_reg        <= '0;
            divisor_reg    <= '0;
            scale_reg      <= SCALE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            ld_row_reg     <= ld_row_next;
            ld_col_reg     <= ld_col_next;
            rd_a_reg       <= rd_a_next;
            rd_b_reg       <= rd_b_next;
            sum_reg        <= sum_next;
            divisor_reg    <= divisor_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg      <= samp_next;
        sq_reg        <= sq_next;
        excl_reg      <= excl_next;
        last_reg      <= last_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
        scale_use_reg <= scale_use_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // sample store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= in_data.sample;
        end
        if (mem_re)
        begin
            mem_q_reg <= store_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> divisor_reg != '0)
        else $error("divider started with zero divisor");

    a_fetch_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> load_count_reg == FULL_CNT)
        else $error("store read before matrix fully loaded");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= FULL_CNT)
        else $error("load count beyond matrix size");

    a_last_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.last |-> out_data_reg.status != STATUS_NOT_LOADED)
        else $error("last flag on a not-loaded result");

    a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside of root state");

endmodule
`default_nettype wire
